>>> design/incremental_slack_max_table_macros.svh
// Assertion macros used by the back end of the slack table design.
`ifndef INCREMENTAL_SLACK_MAX_TABLE_MACROS_SVH
`define INCREMENTAL_SLACK_MAX_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ISMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ISMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ismt_pkg.sv
// Package with types, constants and helper functions of the slack table design.
`timescale 1ns / 1ps
`default_nettype none
package ismt_pkg;

  localparam int DATA_W            = 48;
  localparam int COORD_W           = 24;
  localparam int IDX_W             = 6;
  localparam int DISP_W            = 24;
  localparam int DIST_W            = 26;
  localparam int PROD_W            = 51;
  localparam int ACC_W             = 53;
  localparam int CFG_IDX_W         = 1;
  localparam int ENTRIES_DEF       = 64;
  localparam int JOURNAL_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QP_W              = $clog2(QUEUE_DEPTH);
  localparam int QC_W              = $clog2(QUEUE_DEPTH + 1);
  localparam logic [DISP_W-1:0] DISP_RESET = DISP_W'(65536);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_MOVE   = 2'd1,
    FUNC_QDELAY = 2'd2,
    FUNC_SHIFT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_JFULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_SLACK = 1'd0,
    CFG_UNIT_DLY      = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_DISPATCH,
    BS_DELTA,
    BS_SCAN,
    BS_SHIFT,
    BS_UNDO,
    BS_FIN,
    BS_RESP
  } back_state_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          path_index;
    logic signed [DATA_W-1:0]  delay_value;
    logic [COORD_W-1:0]        source_x;
    logic [COORD_W-1:0]        source_y;
    logic [COORD_W-1:0]        target_x;
    logic [COORD_W-1:0]        target_y;
    logic [COORD_W-1:0]        anchor_x;
    logic [COORD_W-1:0]        anchor_y;
    logic                      batch_last;
    logic                      commit;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  cur_slack;
    logic signed [DATA_W-1:0]  critical_arrival;
    logic [IDX_W-1:0]          critical_index;
    status_t                   status;
  } out_item_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  dv;
    logic signed [DIST_W-1:0]  mdist;
    logic                      last;
    logic                      commit;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

>>> design/ismt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ismt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> design/ismt_front.sv
// Front end: accepts input transactions and turns them into commands.
`timescale 1ns / 1ps
`default_nettype none
module ismt_front
  import ismt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_push,
  output cmd_t          q_data,
  input  wire logic     q_full
);

  logic fe_valid_r, fe_valid_nxt;
  cmd_t fe_cmd_r, fe_cmd_nxt;
  logic take;
  logic [DIST_W-1:0] gain, loss;

  assign in_stall = fe_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = fe_valid_r && !q_full;
  assign q_data   = fe_cmd_r;

  always_comb begin
    gain = DIST_W'(absdiff(in_data.source_x, in_data.anchor_x))
         + DIST_W'(absdiff(in_data.source_y, in_data.anchor_y));
    loss = DIST_W'(absdiff(in_data.target_x, in_data.anchor_x))
         + DIST_W'(absdiff(in_data.target_y, in_data.anchor_y));
    fe_cmd_nxt.func   = in_data.func;
    fe_cmd_nxt.idx    = in_data.path_index;
    fe_cmd_nxt.dv     = in_data.delay_value;
    fe_cmd_nxt.mdist  = signed'(gain - loss);
    fe_cmd_nxt.last   = in_data.batch_last;
    fe_cmd_nxt.commit = in_data.commit;
    fe_valid_nxt = take ? 1'b1 : (q_push ? 1'b0 : fe_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
    if (take) begin
      fe_cmd_r <= fe_cmd_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/ismt_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ismt_queue
  import ismt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QC_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QP_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QP_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> design/ismt_back.sv
// Back end: arrival table, critical tracking, trial journal and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_slack_max_table_macros.svh"
module ismt_back
  import ismt_pkg::*;
#(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  input  wire cmd_t                     q_data,
  output logic                          q_pop,
  input  wire logic signed [DATA_W-1:0] initial_slack,
  input  wire logic [DISP_W-1:0]        unit_dly,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int JA_W   = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int JF_W   = $clog2(JOURNAL_DEPTH + 1);
  localparam int JE_W   = SLOT_W + DATA_W;
  localparam int XW     = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;

  back_state_t              state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [CNT_W-1:0]         entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic [JF_W-1:0]          jcnt_r, jcnt_nxt;
  logic [JF_W-1:0]          jfill_r, jfill_nxt;
  logic                     pend_r, pend_nxt;
  logic [SLOT_W-1:0]        pend_slot_r, pend_slot_nxt;
  logic signed [DATA_W-1:0] crit_r, crit_nxt;
  logic [SLOT_W-1:0]        crit_slot_r, crit_slot_nxt;
  logic signed [DATA_W-1:0] slack_r, slack_nxt;
  logic signed [DATA_W-1:0] base_r, base_nxt;
  logic signed [DATA_W-1:0] j0_val_r, j0_val_nxt;
  logic [SLOT_W-1:0]        j0_slot_r, j0_slot_nxt;
  logic signed [DATA_W-1:0] oldc_r, oldc_nxt;
  logic signed [PROD_W-1:0] mul_r, mul_nxt;
  status_t                  status_r, status_nxt;
  logic                     trial_r, trial_nxt;
  logic                     undo_ret_r, undo_ret_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     t_we;
  logic [SLOT_W-1:0]        t_waddr, t_raddr;
  logic [DATA_W-1:0]        t_wdata, t_rdata_raw;
  logic signed [DATA_W-1:0] t_rdata;
  logic                     j_we;
  logic [JA_W-1:0]          j_waddr, j_raddr;
  logic [JE_W-1:0]          j_wdata, j_rdata;

  logic [XW-1:0]            idx_x, crit_x;
  logic [SLOT_W-1:0]        idx_slot;
  logic                     is_delta, trial_now;
  logic signed [DATA_W-1:0] nv;

  ismt_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata_raw)
  );

  ismt_ram #(.WIDTH(JE_W), .DEPTH(JOURNAL_DEPTH)) u_journal (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

  assign t_rdata   = signed'(t_rdata_raw);
  assign idx_x     = XW'(cmd_r.idx);
  assign idx_slot  = idx_x[SLOT_W-1:0];
  assign crit_x    = XW'(crit_slot_r);
  assign is_delta  = (cmd_r.func == FUNC_MOVE) || (cmd_r.func == FUNC_QDELAY);
  assign trial_now = !cmd_r.commit || (jfill_r != '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    entry_count_nxt = entry_count_r;
    scan_cnt_nxt    = scan_cnt_r;
    jcnt_nxt        = jcnt_r;
    jfill_nxt       = jfill_r;
    pend_nxt        = pend_r;
    pend_slot_nxt   = pend_slot_r;
    crit_nxt        = crit_r;
    crit_slot_nxt   = crit_slot_r;
    slack_nxt       = slack_r;
    base_nxt        = base_r;
    j0_val_nxt      = j0_val_r;
    j0_slot_nxt     = j0_slot_r;
    oldc_nxt        = oldc_r;
    mul_nxt         = mul_r;
    status_nxt      = status_r;
    trial_nxt       = trial_r;
    undo_ret_nxt    = undo_ret_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    q_pop           = 1'b0;
    t_we            = 1'b0;
    t_waddr         = '0;
    t_wdata         = '0;
    t_raddr         = '0;
    j_we            = 1'b0;
    j_waddr         = '0;
    j_wdata         = '0;
    j_raddr         = '0;
    nv              = '0;

    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = BS_DISPATCH;
        end
      end

      BS_DISPATCH: begin
        status_nxt = ST_OK;
        trial_nxt  = 1'b0;
        if (!is_delta && jfill_r != '0) begin
          undo_ret_nxt = 1'b1;
          jcnt_nxt     = jfill_r - 1'b1;
          pend_nxt     = 1'b0;
          state_nxt    = BS_UNDO;
        end else if (cmd_r.func == FUNC_LOAD) begin
          if (idx_x >= XW'(ENTRIES)) begin
            status_nxt = ST_RANGE;
            state_nxt  = BS_FIN;
          end else begin
            t_we      = 1'b1;
            t_waddr   = idx_slot;
            t_wdata   = cmd_r.dv;
            slack_nxt = initial_slack;
            if (XW'(entry_count_r) <= idx_x) begin
              entry_count_nxt = CNT_W'(idx_x + XW'(1));
            end
            state_nxt = BS_FIN;
            if (cmd_r.dv > crit_r) begin
              crit_nxt      = cmd_r.dv;
              crit_slot_nxt = idx_slot;
            end else if (idx_slot == crit_slot_r && cmd_r.dv < crit_r) begin
              crit_nxt     = cmd_r.dv;
              scan_cnt_nxt = '0;
              pend_nxt     = 1'b0;
              state_nxt    = BS_SCAN;
            end
          end
        end else if (cmd_r.func == FUNC_SHIFT) begin
          scan_cnt_nxt = '0;
          pend_nxt     = 1'b0;
          state_nxt    = BS_SHIFT;
        end else begin
          trial_nxt = trial_now;
          if (XW'(entry_count_r) <= idx_x) begin
            status_nxt = ST_RANGE;
            state_nxt  = BS_FIN;
          end else if (trial_now && (JF_W + 1)'(jfill_r)
                       + ((jfill_r == '0) ? (JF_W + 1)'(2) : (JF_W + 1)'(1))
                       > (JF_W + 1)'(JOURNAL_DEPTH)) begin
            status_nxt = ST_JFULL;
            state_nxt  = BS_FIN;
          end else begin
            t_raddr   = idx_slot;
            mul_nxt   = PROD_W'(cmd_r.mdist) * PROD_W'(signed'({1'b0, unit_dly}));
            oldc_nxt  = crit_r;
            state_nxt = BS_DELTA;
          end
        end
      end

      BS_DELTA: begin
        if (trial_r) begin
          j_we    = 1'b1;
          j_wdata = {idx_slot, t_rdata};
          if (jfill_r == '0) begin
            j0_val_nxt  = crit_r;
            j0_slot_nxt = crit_slot_r;
            base_nxt    = crit_r;
            j_waddr     = JA_W'(1);
            jfill_nxt   = JF_W'(2);
          end else begin
            j_waddr   = jfill_r[JA_W-1:0];
            jfill_nxt = jfill_r + 1'b1;
          end
        end
        if (cmd_r.func == FUNC_MOVE) begin
          nv = sat48(ACC_W'(t_rdata) - ACC_W'(mul_r));
        end else begin
          nv = sat48(ACC_W'(t_rdata) + ACC_W'(cmd_r.dv));
        end
        t_we      = 1'b1;
        t_waddr   = idx_slot;
        t_wdata   = nv;
        state_nxt = BS_FIN;
        if (nv > crit_r) begin
          crit_nxt      = nv;
          crit_slot_nxt = idx_slot;
        end else if (idx_slot == crit_slot_r && nv < crit_r) begin
          crit_nxt     = nv;
          scan_cnt_nxt = '0;
          pend_nxt     = 1'b0;
          state_nxt    = BS_SCAN;
        end
      end

      BS_SCAN: begin
        if (pend_r && t_rdata > crit_r) begin
          crit_nxt      = t_rdata;
          crit_slot_nxt = pend_slot_r;
        end
        if (scan_cnt_r < entry_count_r) begin
          t_raddr       = scan_cnt_r[SLOT_W-1:0];
          pend_nxt      = 1'b1;
          pend_slot_nxt = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt  = scan_cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = BS_FIN;
          end
        end
      end

      BS_SHIFT: begin
        if (pend_r) begin
          t_we    = 1'b1;
          t_waddr = pend_slot_r;
          t_wdata = sat48(ACC_W'(t_rdata) + ACC_W'(cmd_r.dv));
        end
        if (scan_cnt_r < entry_count_r) begin
          t_raddr       = scan_cnt_r[SLOT_W-1:0];
          pend_nxt      = 1'b1;
          pend_slot_nxt = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt  = scan_cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            crit_nxt  = sat48(ACC_W'(crit_r) + ACC_W'(cmd_r.dv));
            state_nxt = BS_FIN;
          end
        end
      end

      BS_UNDO: begin
        if (pend_r) begin
          t_we    = 1'b1;
          t_waddr = j_rdata[JE_W-1:DATA_W];
          t_wdata = j_rdata[DATA_W-1:0];
        end
        if (jcnt_r != '0) begin
          j_raddr  = jcnt_r[JA_W-1:0];
          pend_nxt = 1'b1;
          jcnt_nxt = jcnt_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            crit_nxt      = j0_val_r;
            crit_slot_nxt = j0_slot_r;
            jfill_nxt     = '0;
            state_nxt     = undo_ret_r ? BS_DISPATCH : BS_IDLE;
          end
        end
      end

      BS_FIN: begin
        if (is_delta && status_r == ST_OK && !trial_r) begin
          slack_nxt = sat48(ACC_W'(slack_r) + ACC_W'(oldc_r) - ACC_W'(crit_r));
        end
        state_nxt = BS_RESP;
      end

      BS_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.cur_slack        = (jfill_r != '0)
              ? sat48(ACC_W'(slack_r) + ACC_W'(base_r) - ACC_W'(crit_r)) : slack_r;
          out_data_nxt.critical_arrival = crit_r;
          out_data_nxt.critical_index   = crit_x[IDX_W-1:0];
          out_data_nxt.status           = status_r;
          if (is_delta && cmd_r.last && jfill_r != '0) begin
            undo_ret_nxt = 1'b0;
            jcnt_nxt     = jfill_r - 1'b1;
            pend_nxt     = 1'b0;
            state_nxt    = BS_UNDO;
          end else begin
            state_nxt = BS_IDLE;
          end
        end
      end

      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BS_IDLE;
      entry_count_r <= '0;
      jfill_r       <= '0;
      pend_r        <= 1'b0;
      crit_r        <= '0;
      crit_slot_r   <= '0;
      slack_r       <= '0;
      base_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      jfill_r       <= jfill_nxt;
      pend_r        <= pend_nxt;
      crit_r        <= crit_nxt;
      crit_slot_r   <= crit_slot_nxt;
      slack_r       <= slack_nxt;
      base_r        <= base_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    jcnt_r      <= jcnt_nxt;
    pend_slot_r <= pend_slot_nxt;
    j0_val_r    <= j0_val_nxt;
    j0_slot_r   <= j0_slot_nxt;
    oldc_r      <= oldc_nxt;
    mul_r       <= mul_nxt;
    status_r    <= status_nxt;
    trial_r     <= trial_nxt;
    undo_ret_r  <= undo_ret_nxt;
    out_data_r  <= out_data_nxt;
  end

  `ISMT_ASSERT_SAME(a_jfill_bound, 1'b1, jfill_r <= JF_W'(JOURNAL_DEPTH), "journal overfilled")
  `ISMT_ASSERT_SAME(a_count_bound, 1'b1, entry_count_r <= CNT_W'(ENTRIES), "entry count too large")
  `ISMT_ASSERT_NEXT(a_resp_loads, state_r == BS_RESP && (!out_valid_r || !out_stall), out_valid_r, "result not registered")
  `ISMT_ASSERT_NEXT(a_undo_clears, state_r == BS_UNDO && jcnt_r == '0 && !pend_r, jfill_r == '0, "journal not emptied")

endmodule
`default_nettype wire

>>> design/incremental_slack_max_table.sv
// Top level of the incremental slack tracker with its configuration registers.
//
//   Channel  Handshake                 Payload
//   in       in_valid / in_stall       in_data  (in_item_t)
//   out      out_valid / out_stall     out_data (out_item_t)
//   cfg      cfg_we                    cfg_index, cfg_wdata
//
// An in-range delta item passes DISPATCH, DELTA, FIN and RESP; a load skips DELTA.
// A critical drop or a shift of all entries adds a sweep of all loaded entries.
// Undoing a trial batch restores the journaled arrivals through the table write port.
// Reset is synchronous; the table and journal need no clearing pass.
// A stalled result waits in the output register; input then backs up and stalls.
`timescale 1ns / 1ps
`default_nettype none
module incremental_slack_max_table
  import ismt_pkg::*;
#(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata
);

  logic signed [DATA_W-1:0] initial_slack_r, initial_slack_nxt;
  logic [DISP_W-1:0]        unit_dly_r, unit_dly_nxt;
  logic                     q_push, q_full, q_pop, q_empty;
  cmd_t                     q_in, q_head;

  always_comb begin
    initial_slack_nxt = initial_slack_r;
    unit_dly_nxt      = unit_dly_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INITIAL_SLACK: initial_slack_nxt = signed'(cfg_wdata);
        CFG_UNIT_DLY:      unit_dly_nxt      = cfg_wdata[DISP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_slack_r <= '0;
      unit_dly_r      <= DISP_RESET;
    end else begin
      initial_slack_r <= initial_slack_nxt;
      unit_dly_r      <= unit_dly_nxt;
    end
  end

  ismt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  ismt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ismt_back #(
    .ENTRIES       (ENTRIES),
    .JOURNAL_DEPTH (JOURNAL_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .initial_slack (initial_slack_r),
    .unit_dly      (unit_dly_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

>>> dv/tb_incremental_slack_max_table.sv
// Self-checking testbench for the incremental slack tracker with its max table.
`timescale 1ns / 1ps
`default_nettype none
module tb_incremental_slack_max_table;
  import ismt_pkg::*;

  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam int NSLOT = 64;
  localparam int JDEPTH = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;

  class slack_scoreboard;
    longint arrival[NSLOT];
    int unsigned loaded;
    longint crit_val;
    int unsigned crit_idx;
    longint slack;
    longint base_crit;
    int unsigned jslot[JDEPTH];
    longint jval[JDEPTH];
    int unsigned jfill;
    longint init_slack;
    longint unit_delay;
    out_item_t pending[$];
    int errors;

    function new();
      loaded = 0;
      crit_val = 0;
      crit_idx = 0;
      slack = 0;
      base_crit = 0;
      jfill = 0;
      init_slack = 0;
      unit_delay = 65536;
      errors = 0;
    endfunction

    function longint clip48(longint v);
      if (v > MAX48) return MAX48;
      if (v < MIN48) return MIN48;
      return v;
    endfunction

    function longint mdist(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
      if (idx == CFG_INITIAL_SLACK) init_slack = longint'($signed(val));
      else unit_delay = longint'(val[DISP_W-1:0]);
    endfunction

    function void follow_crit(int unsigned idx, longint v);
      if (v > crit_val) begin
        crit_val = v;
        crit_idx = idx;
      end else if (idx == crit_idx && v < crit_val) begin
        crit_val = v;
        for (int i = 0; i < loaded; i++) begin
          if (arrival[i] > crit_val) begin
            crit_val = arrival[i];
            crit_idx = i;
          end
        end
      end
    endfunction

    function void roll_back();
      if (jfill == 0) return;
      for (int k = jfill - 1; k >= 1; k--) arrival[jslot[k]] = jval[k];
      crit_idx = jslot[0];
      crit_val = jval[0];
      jfill = 0;
    endfunction

    function void note_input(in_item_t t);
      out_item_t e;
      status_t st;
      longint dv;
      longint oldc;
      longint nv;
      longint slack_now;
      int unsigned idx;
      bit trial;
      st = ST_OK;
      dv = longint'(t.delay_value);
      idx = t.path_index;
      if (t.func == FUNC_LOAD || t.func == FUNC_SHIFT) begin
        roll_back();
        if (t.func == FUNC_LOAD) begin
          arrival[idx] = dv;
          if (idx + 1 > loaded) loaded = idx + 1;
          follow_crit(idx, dv);
          slack = init_slack;
        end else begin
          for (int i = 0; i < loaded; i++) arrival[i] = clip48(arrival[i] + dv);
          crit_val = clip48(crit_val + dv);
        end
        slack_now = slack;
      end else begin
        trial = !t.commit || jfill > 0;
        if (idx >= loaded) begin
          st = ST_RANGE;
        end else if (trial && jfill + ((jfill == 0) ? 2 : 1) > JDEPTH) begin
          st = ST_JFULL;
        end else begin
          oldc = crit_val;
          if (trial) begin
            if (jfill == 0) begin
              jslot[0] = crit_idx;
              jval[0] = crit_val;
              base_crit = crit_val;
              jfill = 1;
            end
            jslot[jfill] = idx;
            jval[jfill] = arrival[idx];
            jfill++;
          end
          if (t.func == FUNC_MOVE) begin
            nv = mdist(t.source_x, t.anchor_x) + mdist(t.source_y, t.anchor_y)
                 - mdist(t.target_x, t.anchor_x) - mdist(t.target_y, t.anchor_y);
            nv = clip48(arrival[idx] - nv * unit_delay);
          end else begin
            nv = clip48(arrival[idx] + dv);
          end
          arrival[idx] = nv;
          follow_crit(idx, nv);
          if (!trial) slack = clip48(slack + (oldc - crit_val));
        end
        slack_now = (jfill > 0) ? clip48(slack + (base_crit - crit_val)) : slack;
      end
      e.cur_slack = slack_now[DATA_W-1:0];
      e.critical_arrival = crit_val[DATA_W-1:0];
      e.critical_index = crit_idx[IDX_W-1:0];
      e.status = st;
      pending = {pending, e};
      if (t.func != FUNC_LOAD && t.func != FUNC_SHIFT && t.batch_last) roll_back();
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.cur_slack !== e.cur_slack) begin
        $error("cur_slack: expected %0d, got %0d", e.cur_slack, r.cur_slack);
        errors++;
      end
      if (r.critical_arrival !== e.critical_arrival) begin
        $error("critical_arrival: expected %0d, got %0d", e.critical_arrival,
               r.critical_arrival);
        errors++;
      end
      if (r.critical_index !== e.critical_index) begin
        $error("critical_index: expected %0d, got %0d", e.critical_index,
               r.critical_index);
        errors++;
      end
      if (r.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, r.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  slack_scoreboard sb;
  bit quiet;
  int idle_cycles;
  int stall_left;
  int batch_left;
  bit batch_commit;

  incremental_slack_max_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("incremental_slack_max_table regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(DATA_W-1){1'b1}}};
      1: return {1'b1, {(DATA_W-1){1'b0}}};
      2, 3: return DATA_W'({$urandom, $urandom});
      default: return DATA_W'(longint'($signed($urandom_range(0, 2097151))) - 1048576);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t make_item(func_t f, int idx, logic [DATA_W-1:0] dv,
                                         bit last, bit keep);
    in_item_t t;
    t.func = f;
    t.path_index = idx[IDX_W-1:0];
    t.delay_value = dv;
    t.source_x = pick_coord();
    t.source_y = pick_coord();
    t.target_x = pick_coord();
    t.target_y = pick_coord();
    t.anchor_x = pick_coord();
    t.anchor_y = pick_coord();
    t.batch_last = last;
    t.commit = keep;
    return t;
  endfunction

  function automatic in_item_t random_item();
    int r;
    int idx;
    bit last;
    bit keep;
    r = $urandom_range(0, 99);
    if (sb.loaded == 0 || r < 12) begin
      if (sb.loaded < NSLOT && $urandom_range(0, 1)) idx = sb.loaded;
      else idx = $urandom_range(0, (sb.loaded < NSLOT) ? sb.loaded : NSLOT - 1);
      return make_item(FUNC_LOAD, idx, pick_delay(), $urandom_range(0, 1),
                       $urandom_range(0, 1));
    end
    if (r < 16) begin
      return make_item(FUNC_SHIFT, $urandom_range(0, 63), pick_delay(),
                       $urandom_range(0, 1), $urandom_range(0, 1));
    end
    if (batch_left == 0) begin
      batch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                               : $urandom_range(1, 6);
      batch_commit = ($urandom_range(0, 9) < 3);
    end
    idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                       : $urandom_range(0, sb.loaded - 1);
    last = (batch_left == 1);
    keep = batch_commit;
    batch_left--;
    if ($urandom_range(0, 19) == 0) begin
      last = $urandom_range(0, 1);
      keep = $urandom_range(0, 1);
    end
    return make_item(($urandom_range(0, 1) != 0) ? FUNC_MOVE : FUNC_QDELAY, idx,
                     pick_delay(), last, keep);
  endfunction

  task automatic send_item(in_item_t t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] max_v;
    logic [DATA_W-1:0] min_v;
    max_v = {1'b0, {(DATA_W-1){1'b1}}};
    min_v = {1'b1, {(DATA_W-1){1'b0}}};
    sb = new();
    quiet = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    batch_left = 0;
    batch_commit = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_INITIAL_SLACK, '0);
    write_reg(CFG_UNIT_DLY, DATA_W'(65536));
    send_item(make_item(FUNC_QDELAY, 0, 48'd5, 1'b1, 1'b1));
    send_item(make_item(FUNC_LOAD, 0, max_v, 1'b0, 1'b1));
    send_item(make_item(FUNC_LOAD, 1, min_v, 1'b0, 1'b1));
    send_item(make_item(FUNC_LOAD, 2, 48'd0, 1'b0, 1'b1));
    send_item(make_item(FUNC_LOAD, 3, 48'd1000, 1'b0, 1'b1));
    send_item(make_item(FUNC_QDELAY, 0, min_v, 1'b1, 1'b1));
    send_item(make_item(FUNC_MOVE, 3, '0, 1'b1, 1'b1));
    send_item(make_item(FUNC_QDELAY, 2, 48'd70000, 1'b0, 1'b0));
    send_item(make_item(FUNC_MOVE, 1, '0, 1'b0, 1'b0));
    send_item(make_item(FUNC_QDELAY, 2, min_v, 1'b1, 1'b0));
    send_item(make_item(FUNC_QDELAY, 3, 48'd12, 1'b0, 1'b0));
    send_item(make_item(FUNC_LOAD, 4, 48'd77, 1'b0, 1'b1));
    send_item(make_item(FUNC_SHIFT, 0, max_v, 1'b0, 1'b1));
    send_item(make_item(FUNC_SHIFT, 0, min_v, 1'b0, 1'b1));
    send_item(make_item(FUNC_SHIFT, 0, min_v, 1'b0, 1'b1));
    send_item(make_item(FUNC_QDELAY, 63, 48'd1, 1'b1, 1'b1));
    send_item(make_item(FUNC_MOVE, 5, '0, 1'b1, 1'b0));
    send_item(make_item(FUNC_LOAD, 5, 48'd9, 1'b0, 1'b1));
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            write_reg(CFG_INITIAL_SLACK, max_v);
            write_reg(CFG_UNIT_DLY, DATA_W'(24'hFF_FFFF));
          end
          2: begin
            write_reg(CFG_INITIAL_SLACK, min_v);
            write_reg(CFG_UNIT_DLY, '0);
          end
          default: begin
            write_reg(CFG_INITIAL_SLACK, DATA_W'({$urandom, $urandom}));
            write_reg(CFG_UNIT_DLY, DATA_W'($urandom_range(0, 24'hFF_FFFF)));
          end
        endcase
      end
      quiet = (phase == 3);
      for (int n = 0; n < 275; n++) send_item(random_item());
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("incremental_slack_max_table regression: pass");
    end else begin
      $display("incremental_slack_max_table regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/ismt_pkg.sv
design/ismt_ram.sv
design/ismt_front.sv
design/ismt_queue.sv
design/ismt_back.sv
design/incremental_slack_max_table.sv
dv/tb_incremental_slack_max_table.sv
